>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the cell and sequencer RTL files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> hw/rtl/mlt_pkg.sv
// ---------------------------------------------------------------------------
// MAC learning table package
// Widths, constants and shared types of the MAC learning table.
// ---------------------------------------------------------------------------
package mlt_pkg;

   localparam int MacWidth          = 48;
   localparam int PortWidth         = 32;
   localparam int AgeWidth          = 8;
   localparam int DefaultTableDepth = 64;
   localparam int CsrAddrWidth      = 3;
   localparam int CsrDataWidth      = 32;

   localparam logic [AgeWidth-1:0]          AgingLimitReset = 8'd30;
   localparam logic [CsrAddrWidth-3:0]      CsrIdxAgingLimit = 1'b0;

   typedef struct packed {
      logic                 active;
      logic                 src_hit;
      logic                 free_claimed;
      logic                 dst_hit;
      logic [PortWidth-1:0] dst_port;
   } carry_type;

   typedef struct packed {
      logic [MacWidth-1:0]  src_mac;
      logic [MacWidth-1:0]  dst_mac;
      logic [PortWidth-1:0] in_port;
      logic [AgeWidth-1:0]  limit;
      logic                 tick;
      logic                 commit;
      logic                 finish;
   } bcast_type;

endpackage

>>> hw/rtl/mlt_if.sv
// ---------------------------------------------------------------------------
// MAC learning table channels
// Request and response handshake channels of the MAC learning table.
// ---------------------------------------------------------------------------
interface mlt_req_if;
   import mlt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [MacWidth-1:0]  src_mac;
   logic [MacWidth-1:0]  dst_mac;
   logic [PortWidth-1:0] in_port;

   modport source (output valid, kind, src_mac, dst_mac, in_port, input ready);
   modport sink   (input valid, kind, src_mac, dst_mac, in_port, output ready);
endinterface

interface mlt_rsp_if;
   import mlt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 flood;
   logic [PortWidth-1:0] out_port;
   logic                 learn_dropped;

   modport source (output valid, flood, out_port, learn_dropped, input ready);
   modport sink   (input valid, flood, out_port, learn_dropped, output ready);
endinterface

>>> hw/rtl/mlt_cell.sv
// ---------------------------------------------------------------------------
// MAC learning table cell
// One table entry; compares the passing item against its entry and hands
// the running search result to the next cell.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mlt_cell (
   input  logic                clock,
   input  logic                reset,
   input  mlt_pkg::bcast_type  bcast,
   input  mlt_pkg::carry_type  carry_in,
   output mlt_pkg::carry_type  carry_out
);
   import mlt_pkg::*;

   logic                 valid_ff, valid_in;
   logic                 pending_ff, pending_in;
   logic [MacWidth-1:0]  mac_ff, mac_in;
   logic [PortWidth-1:0] port_ff, port_in;
   logic [AgeWidth-1:0]  age_ff, age_in;
   carry_type            carry_ff, carry_in_next;

   logic src_match;
   logic dst_match;
   logic claim;

   always_comb begin
      src_match = carry_in.active && valid_ff && (mac_ff == bcast.src_mac);
      dst_match = carry_in.active && valid_ff && (mac_ff == bcast.dst_mac);
      claim     = carry_in.active && !valid_ff && !carry_in.free_claimed;

      valid_in   = valid_ff;
      pending_in = pending_ff;
      mac_in     = mac_ff;
      port_in    = port_ff;
      age_in     = age_ff;

      if (src_match) begin
         port_in = bcast.in_port;
         age_in  = bcast.limit;
      end

      if (claim) begin
         pending_in = 1'b1;
      end else if (bcast.finish) begin
         pending_in = 1'b0;
      end

      if (bcast.commit && pending_ff) begin
         valid_in = 1'b1;
         mac_in   = bcast.src_mac;
         port_in  = bcast.in_port;
         age_in   = bcast.limit;
      end

      if (bcast.tick && valid_ff) begin
         if (age_ff <= AgeWidth'(1)) begin
            valid_in = 1'b0;
            age_in   = '0;
         end else begin
            age_in = age_ff - AgeWidth'(1);
         end
      end

      carry_in_next.active       = carry_in.active;
      carry_in_next.src_hit      = carry_in.src_hit | src_match;
      carry_in_next.free_claimed = carry_in.free_claimed | claim;
      carry_in_next.dst_hit      = carry_in.dst_hit | dst_match;
      carry_in_next.dst_port     = dst_match ? port_ff : carry_in.dst_port;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         pending_ff <= 1'b0;
         carry_ff   <= '0;
      end else begin
         valid_ff   <= valid_in;
         pending_ff <= pending_in;
         carry_ff   <= carry_in_next;
      end
   end

   always_ff @(posedge clock) begin
      mac_ff  <= mac_in;
      port_ff <= port_in;
      age_ff  <= age_in;
   end

   assign carry_out = carry_ff;

   `ASSERT_IMPLIES(a_pending_free, clock, reset, pending_ff, !valid_ff, "claimed slot is in use")
   `ASSERT_HOLDS(a_tick_idle, clock, reset, !(bcast.tick && carry_in.active), "tick during sweep")
   `ASSERT_NEXT(a_commit_fill, clock, reset, bcast.commit && pending_ff, valid_ff, "fill lost")

endmodule

>>> hw/rtl/mlt_ctrl.sv
// ---------------------------------------------------------------------------
// MAC learning table sequencer
// Takes items, launches the sweep down the cell chain, resolves learning
// and lookup at its end and holds the result item.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mlt_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   mlt_req_if.sink                      req,
   mlt_rsp_if.source                    rsp,
   input  logic [mlt_pkg::AgeWidth-1:0] aging_limit,
   input  mlt_pkg::carry_type           carry_last,
   output mlt_pkg::carry_type           carry_first,
   output mlt_pkg::bcast_type           bcast
);
   import mlt_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SWEEP = 2'd1;
   localparam logic [1:0] ST_DONE  = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic                 start_ff, start_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 flood_ff, flood_in;
   logic [PortWidth-1:0] out_port_ff, out_port_in;
   logic                 dropped_ff, dropped_in;
   logic [MacWidth-1:0]  src_ff, src_in;
   logic [MacWidth-1:0]  dst_ff, dst_in;
   logic [PortWidth-1:0] port_ff, port_in;
   logic [AgeWidth-1:0]  limit_ff, limit_in;
   carry_type            res_ff, res_in;

   logic accept;
   logic out_free;
   logic finish;
   logic dropped;

   always_comb begin
      accept   = req.valid && req.ready;
      out_free = !rsp_valid_ff || rsp.ready;
      finish   = (state_ff == ST_DONE) && out_free;
      dropped  = !res_ff.src_hit && !res_ff.free_claimed;

      state_in     = state_ff;
      start_in     = accept && !req.kind;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      flood_in     = flood_ff;
      out_port_in  = out_port_ff;
      dropped_in   = dropped_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      port_in      = port_ff;
      limit_in     = limit_ff;
      res_in       = res_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept && !req.kind) begin
               src_in   = req.src_mac;
               dst_in   = req.dst_mac;
               port_in  = req.in_port;
               limit_in = (aging_limit == '0) ? AgeWidth'(1) : aging_limit;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (carry_last.active) begin
               res_in   = carry_last;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               dropped_in   = dropped;
               if ((dst_ff == src_ff) && !dropped) begin
                  flood_in    = 1'b0;
                  out_port_in = port_ff;
               end else if (res_ff.dst_hit) begin
                  flood_in    = 1'b0;
                  out_port_in = res_ff.dst_port;
               end else begin
                  flood_in    = 1'b1;
                  out_port_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flood_ff    <= flood_in;
      out_port_ff <= out_port_in;
      dropped_ff  <= dropped_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      port_ff     <= port_in;
      limit_ff    <= limit_in;
      res_ff      <= res_in;
   end

   always_comb begin
      carry_first              = '0;
      carry_first.active       = start_ff;
      bcast.src_mac            = src_ff;
      bcast.dst_mac            = dst_ff;
      bcast.in_port            = port_ff;
      bcast.limit              = limit_ff;
      bcast.tick               = accept && req.kind;
      bcast.finish             = finish;
      bcast.commit             = finish && !res_ff.src_hit && res_ff.free_claimed;
   end

   assign req.ready         = (state_ff == ST_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.flood         = flood_ff;
   assign rsp.out_port      = out_port_ff;
   assign rsp.learn_dropped = dropped_ff;

   `ASSERT_IMPLIES(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == ST_DONE, "result issued outside done")
   `ASSERT_IMPLIES(a_last_in_sweep, clock, reset, carry_last.active,
      state_ff == ST_SWEEP, "sweep ended outside sweep state")
   `ASSERT_NEXT(a_start_sweep, clock, reset, start_ff, state_ff == ST_SWEEP,
      "sweep launched without sweep state")

endmodule

>>> hw/rtl/mac_learning_table_with_aging.sv
// ---------------------------------------------------------------------------
// MAC learning table with aging
// Layer-2 forwarding table: learns sources, looks up destinations and
// ages entries out.
// ---------------------------------------------------------------------------
// Usage:
//   req_bus carries one item per valid/ready handshake. kind 0 is a frame:
//   src_mac is learned with in_port, then dst_mac is looked up. kind 1 is an
//   aging tick and produces no result.
//   rsp_bus returns one item per frame: flood, out_port, learn_dropped.
//   A tick is applied at the edge that accepts it; the block stays ready,
//   so the next item can be taken in the next cycle.
//   A frame walks the chain of TABLE_DEPTH cells, one cell per cycle; at
//   the end of the chain its result is registered and offered, and the
//   block takes no new item until that result is in the output register.
//   A result held by a stalled receiver only delays the end of the
//   following frame.
//   Reset empties the table and sets aging_limit to 30; the table is usable
//   in the first cycle after reset. aging_limit sits at byte address 0 of
//   the APB port; write it only while no item is in flight.
// ---------------------------------------------------------------------------
module mac_learning_table_with_aging #(
   parameter int TABLE_DEPTH = mlt_pkg::DefaultTableDepth
) (
   input  logic                              clock,
   input  logic                              reset,
   mlt_req_if.sink                           req_bus,
   mlt_rsp_if.source                         rsp_bus,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [mlt_pkg::CsrAddrWidth-1:0]  paddr,
   input  logic [mlt_pkg::CsrDataWidth-1:0]  pwdata,
   output logic [mlt_pkg::CsrDataWidth-1:0]  prdata,
   output logic                              pready
);
   import mlt_pkg::*;

   logic [AgeWidth-1:0] aging_limit_ff, aging_limit_in;
   logic                csr_hit;
   logic                csr_write;
   carry_type           carry_w [0:TABLE_DEPTH];
   bcast_type           bcast;

   always_comb begin
      csr_hit        = (paddr[CsrAddrWidth-1:2] == CsrIdxAgingLimit);
      csr_write      = psel && penable && pwrite && pready;
      aging_limit_in = (csr_write && csr_hit) ? pwdata[AgeWidth-1:0] : aging_limit_ff;
      prdata         = csr_hit ? CsrDataWidth'(aging_limit_ff) : '0;
   end

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         aging_limit_ff <= AgingLimitReset;
      end else begin
         aging_limit_ff <= aging_limit_in;
      end
   end

   mlt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .aging_limit (aging_limit_ff),
      .carry_last  (carry_w[TABLE_DEPTH]),
      .carry_first (carry_w[0]),
      .bcast       (bcast)
   );

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      mlt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .bcast     (bcast),
         .carry_in  (carry_w[i]),
         .carry_out (carry_w[i+1])
      );
   end

endmodule

>>> test/mac_learning_table_with_aging_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MAC learning table testbench
// Sends frames and aging ticks through the request channel, tracks the
// forwarding table alongside the block and checks every forwarding decision.
// ---------------------------------------------------------------------------
module mac_learning_table_with_aging_tb;
   import mlt_pkg::*;

   localparam int TableDepth   = DefaultTableDepth;
   localparam int CycleLimit   = 1_000_000;
   localparam int SettleCycles = TableDepth + 8;
   localparam int HoldCycles   = 600;
   localparam int MaxGap       = 18;

   localparam logic [CsrAddrWidth-1:0] AgingLimitAddr = {CsrIdxAgingLimit, 2'b00};
   localparam logic [CsrAddrWidth-1:0] UnusedAddr     = {~CsrIdxAgingLimit, 2'b00};

   localparam logic KindFrame = 1'b0;
   localparam logic KindTick  = 1'b1;

   typedef struct packed {
      logic                 flood;
      logic [PortWidth-1:0] out_port;
      logic                 learn_dropped;
   } forward_result_type;

   class mac_table_tracker;
      bit                 valid [TableDepth];
      bit [MacWidth-1:0]  mac   [TableDepth];
      bit [PortWidth-1:0] port  [TableDepth];
      bit [AgeWidth-1:0]  age   [TableDepth];
      bit [AgeWidth-1:0]  aging_limit = AgingLimitReset;
      forward_result_type pending_forwards [$];
      int                 errors;

      function int find_slot(logic [MacWidth-1:0] addr);
         for (int i = 0; i < TableDepth; i++) begin
            if (valid[i] && mac[i] == addr) return i;
         end
         return -1;
      endfunction

      function void learn_and_forward(logic kind, logic [MacWidth-1:0] src,
                                      logic [MacWidth-1:0] dst,
                                      logic [PortWidth-1:0] in_port);
         int                 slot;
         bit [AgeWidth-1:0]  life;
         forward_result_type res;
         if (kind == KindTick) begin
            for (int i = 0; i < TableDepth; i++) begin
               if (valid[i]) begin
                  if (age[i] <= AgeWidth'(1)) begin
                     age[i]   = '0;
                     valid[i] = 1'b0;
                  end else begin
                     age[i] = age[i] - AgeWidth'(1);
                  end
               end
            end
            return;
         end
         life = (aging_limit == '0) ? AgeWidth'(1) : aging_limit;
         slot = find_slot(src);
         for (int i = 0; i < TableDepth && slot < 0; i++) begin
            if (!valid[i]) slot = i;
         end
         res.learn_dropped = (slot < 0);
         if (slot >= 0) begin
            valid[slot] = 1'b1;
            mac[slot]   = src;
            port[slot]  = in_port;
            age[slot]   = life;
         end
         slot = find_slot(dst);
         res.flood    = (slot < 0);
         res.out_port = (slot < 0) ? '0 : port[slot];
         pending_forwards.push_back(res);
      endfunction

      function void check_forward(forward_result_type got);
         forward_result_type want;
         if (pending_forwards.size() == 0) begin
            $error("unexpected item: flood %0d out_port %0h learn_dropped %0d",
                   got.flood, got.out_port, got.learn_dropped);
            errors++;
            return;
         end
         want = pending_forwards.pop_front();
         if (got.flood !== want.flood) begin
            $error("flood: expected %0d, got %0d", want.flood, got.flood);
            errors++;
         end
         if (got.out_port !== want.out_port) begin
            $error("out_port: expected %0h, got %0h", want.out_port, got.out_port);
            errors++;
         end
         if (got.learn_dropped !== want.learn_dropped) begin
            $error("learn_dropped: expected %0d, got %0d",
                   want.learn_dropped, got.learn_dropped);
            errors++;
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CsrAddrWidth-1:0] paddr;
   logic [CsrDataWidth-1:0] pwdata;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   mlt_req_if req_bus ();
   mlt_rsp_if rsp_bus ();

   mac_table_tracker tracker = new();
   bit idle_on;
   bit hold_request;
   int cycles = 0;

   mac_learning_table_with_aging #(
      .TABLE_DEPTH(TableDepth)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("mac_learning_table_with_aging: mismatch");
         $finish;
      end
   end

   function automatic logic [MacWidth-1:0] rand_mac();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[MacWidth-1:0];
   endfunction

   function automatic logic [PortWidth-1:0] rand_port();
      case ($urandom_range(9, 0))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   task automatic put_item(logic kind, logic [MacWidth-1:0] src,
                           logic [MacWidth-1:0] dst, logic [PortWidth-1:0] in_port);
      int gap;
      gap = idle_on ? $urandom_range(MaxGap, 0) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.kind    <= kind;
      req_bus.src_mac <= src;
      req_bus.dst_mac <= dst;
      req_bus.in_port <= in_port;
      do @(posedge clock); while (!req_bus.ready);
      tracker.learn_and_forward(kind, src, dst, in_port);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (tracker.pending_forwards.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(logic [CsrAddrWidth-1:0] addr, logic [AgeWidth-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= CsrDataWidth'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == AgingLimitAddr) tracker.aging_limit = value;
   endtask

   task automatic run_phase(logic [AgeWidth-1:0] limit, int n_items, int pool_size,
                            int tick_pct, bit with_hold);
      logic [MacWidth-1:0] pool [$];
      logic [MacWidth-1:0] src;
      logic [MacWidth-1:0] dst;
      logic                kind;
      drain();
      write_csr(AgingLimitAddr, limit);
      for (int i = 0; i < pool_size; i++) pool.push_back(rand_mac());
      for (int n = 0; n < n_items; n++) begin
         idle_on = ((n / 40) % 3) != 2;
         if (with_hold && n == 20) hold_request = 1'b1;
         if (n == n_items / 2) drain();
         kind = ($urandom_range(99, 0) < tick_pct) ? KindTick : KindFrame;
         src  = ($urandom_range(9, 0) < 8) ? pool[$urandom_range(pool_size - 1, 0)]
                                            : rand_mac();
         case ($urandom_range(9, 0))
            0: dst = src;
            1: dst = rand_mac();
            default: dst = pool[$urandom_range(pool_size - 1, 0)];
         endcase
         put_item(kind, src, dst, rand_port());
      end
   endtask

   initial begin
      int                 stall;
      forward_result_type got;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      rsp_bus.ready <= 1'b1;
      forever begin
         do @(posedge clock); while (!rsp_bus.valid);
         got.flood         = rsp_bus.flood;
         got.out_port      = rsp_bus.out_port;
         got.learn_dropped = rsp_bus.learn_dropped;
         tracker.check_forward(got);
         stall = hold_request ? HoldCycles : (idle_on ? $urandom_range(MaxGap, 0) : 0);
         hold_request = 1'b0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [MacWidth-1:0] mac_a;
      logic [MacWidth-1:0] mac_b;
      logic [MacWidth-1:0] mac_c;
      logic [MacWidth-1:0] mac_d;
      mac_a = rand_mac();
      mac_b = rand_mac();
      mac_c = rand_mac();
      mac_d = rand_mac();
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.kind    <= KindFrame;
      req_bus.src_mac <= '0;
      req_bus.dst_mac <= '0;
      req_bus.in_port <= '0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      idle_on      = 1'b0;
      hold_request = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      put_item(KindFrame, '0, '0, '0);
      put_item(KindFrame, '1, '1, '1);
      put_item(KindFrame, mac_a, mac_b, rand_port());
      put_item(KindFrame, mac_b, mac_a, 32'h8000_0001);
      put_item(KindFrame, mac_a, mac_b, 32'h7fff_fffe);
      put_item(KindFrame, mac_c, mac_a, rand_port());
      put_item(KindTick, '1, '1, '1);
      put_item(KindTick, '0, '0, '0);
      put_item(KindFrame, mac_b, '1, rand_port());
      drain();
      write_csr(UnusedAddr, 8'd1);
      write_csr(AgingLimitAddr, 8'd0);
      put_item(KindFrame, mac_d, mac_d, rand_port());
      put_item(KindTick, rand_mac(), rand_mac(), rand_port());
      put_item(KindFrame, mac_a, mac_d, rand_port());
      put_item(KindFrame, mac_c, mac_a, rand_port());
      drain();
      write_csr(AgingLimitAddr, 8'd1);
      put_item(KindFrame, mac_d, mac_a, rand_port());
      put_item(KindTick, rand_mac(), rand_mac(), rand_port());
      put_item(KindFrame, mac_b, mac_d, rand_port());
      put_item(KindFrame, '0, mac_b, rand_port());
      drain();
      write_csr(AgingLimitAddr, 8'd255);
      put_item(KindFrame, mac_c, mac_c, '1);
      put_item(KindTick, '0, '0, '0);
      put_item(KindFrame, mac_a, mac_c, '0);

      run_phase(8'd255, 170, 100, 3, 1'b0);
      run_phase(8'd3, 170, 40, 25, 1'b1);
      run_phase(8'd1, 150, 20, 30, 1'b0);
      run_phase(8'd0, 130, 20, 30, 1'b0);
      run_phase(8'd30, 170, 70, 10, 1'b0);
      run_phase(8'd12, 150, 90, 15, 1'b0);
      run_phase(8'd255, 140, 30, 50, 1'b0);
      drain();

      if (tracker.errors == 0) begin
         $display("mac_learning_table_with_aging: match");
      end else begin
         $display("mac_learning_table_with_aging: mismatch");
      end
      $finish;
   end

endmodule

>>> mac_learning_table_with_aging.f
+incdir+hw/rtl
hw/rtl/mlt_pkg.sv
hw/rtl/mlt_if.sv
hw/rtl/mlt_cell.sv
hw/rtl/mlt_ctrl.sv
hw/rtl/mac_learning_table_with_aging.sv
test/mac_learning_table_with_aging_tb.sv
